[hw/rtl/spq_pkg.sv]
// Shared types, constants and scale tables for the scale pitch quantizer.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package spq_pkg;

  // Pitch format: signed semitones with FRAC_BITS fraction bits.
  localparam int FRAC_BITS = 8;
  localparam int PITCH_W   = 16;
  localparam int ROOT_W    = 16;
  localparam int CFG_W     = 16;
  localparam int MODE_W    = 2;
  localparam int DEG_W     = 3;
  localparam int NOTES     = 8;
  localparam int SEMI_W    = 4;

  // Difference of two pitches, one bit wider than a pitch.
  localparam int DIFF_W    = PITCH_W + 1;
  // One octave is 12 units = 3 << (FRAC_BITS + 2).
  localparam int OCT_SHIFT = FRAC_BITS + 2;
  localparam int HI_W      = DIFF_W - OCT_SHIFT;
  // Offset above the root inside one octave, [0, 12 units).
  localparam int REL_W     = OCT_SHIFT + 2;
  // Snapped pitch before saturation.
  localparam int RES_W     = PITCH_W + 2;

  typedef enum logic [0:0] {
    CFG_ROOT_PITCH = 1'b0,
    CFG_SCALE_MODE = 1'b1
  } cfg_index_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_MAJOR      = 2'd0,
    MODE_NAT_MINOR  = 2'd1,
    MODE_HARM_MINOR = 2'd2
  } scale_mode_e;

  typedef logic [NOTES-1:0][SEMI_W-1:0] note_row_t;

  // Scale degrees in semitones above the root, degree 0 in the low nibble.
  localparam note_row_t MAJOR_NOTES =
    {4'd12, 4'd11, 4'd9, 4'd7, 4'd5, 4'd4, 4'd2, 4'd0};
  localparam note_row_t NAT_MINOR_NOTES =
    {4'd12, 4'd10, 4'd8, 4'd7, 4'd5, 4'd3, 4'd2, 4'd0};
  localparam note_row_t HARM_MINOR_NOTES =
    {4'd12, 4'd11, 4'd8, 4'd7, 4'd5, 4'd3, 4'd2, 4'd0};

  // The unused mode code falls back to the major scale.
  function automatic note_row_t scale_row(input logic [MODE_W-1:0] mode);
    note_row_t row;
    case (mode)
      MODE_MAJOR:      row = MAJOR_NOTES;
      MODE_NAT_MINOR:  row = NAT_MINOR_NOTES;
      MODE_HARM_MINOR: row = HARM_MINOR_NOTES;
      default:         row = MAJOR_NOTES;
    endcase
    return row;
  endfunction

  // Octave fold result handed to the snapping stage.
  typedef struct packed {
    logic [REL_W-1:0] rel;
  } fold_t;

endpackage

`default_nettype wire

[hw/rtl/spq_fold.sv]
// Octave fold: offset of the pitch above the root, reduced into [0, 12 units).
// Depends on spq_pkg.
`default_nettype none

module spq_fold (
  input  wire logic [spq_pkg::PITCH_W-1:0] pitch_i,
  input  wire logic [spq_pkg::ROOT_W-1:0]  root_i,
  output spq_pkg::fold_t                   fold_o
);
  import spq_pkg::*;

  // Floor remainder by 3 of a signed value, most significant bit first.
  // The sign bit weighs -2^(n-1), so Horner's rule starts from -1 mod 3 = 2.
  function automatic logic [1:0] mod3_signed(input logic [HI_W-1:0] v);
    logic [1:0] r;
    logic [2:0] t;
    r = v[HI_W-1] ? 2'd2 : 2'd0;
    for (int b = HI_W - 2; b >= 0; b--) begin
      t = {r, v[b]};
      r = (t >= 3'd3) ? 2'(t - 3'd3) : t[1:0];
    end
    return r;
  endfunction

  logic signed [DIFF_W-1:0] diff;
  logic [1:0]               hi_mod;

  // The octave is 3 << OCT_SHIFT: the low bits pass through, and only the
  // floor quotient by 1 << OCT_SHIFT needs its remainder by 3.
  assign diff   = $signed({pitch_i[PITCH_W-1], pitch_i}) - $signed({root_i[ROOT_W-1], root_i});
  assign hi_mod = mod3_signed(diff[DIFF_W-1:OCT_SHIFT]);

  assign fold_o.rel = {hi_mod, diff[OCT_SHIFT-1:0]};

endmodule

`default_nettype wire

[hw/rtl/spq_snap.sv]
// Degree selection against scale midpoints and saturated snapped pitch.
// Depends on spq_pkg.
`default_nettype none

module spq_snap (
  input  wire logic [spq_pkg::PITCH_W-1:0] pitch_i,
  input  wire logic [spq_pkg::MODE_W-1:0]  mode_i,
  input  wire spq_pkg::fold_t              fold_i,
  output logic [spq_pkg::PITCH_W-1:0]      snapped_o,
  output logic [spq_pkg::DEG_W-1:0]        degree_o
);
  import spq_pkg::*;

  note_row_t               row;
  logic [NOTES-2:0]        below_mid;
  logic [DEG_W-1:0]        degree;
  logic [REL_W-1:0]        note_off;
  logic signed [RES_W-1:0] res;

  assign row = scale_row(mode_i);

  // A midpoint (a + b) / 2 in units is (a + b) << (FRAC_BITS - 1).
  always_comb begin
    for (int i = 0; i < NOTES - 1; i++) begin
      below_mid[i] = fold_i.rel <
        (REL_W'({1'b0, row[i]} + {1'b0, row[i+1]}) << (FRAC_BITS - 1));
    end
  end

  // First degree whose upper midpoint lies above the offset; a tie goes up.
  always_comb begin
    degree = DEG_W'(NOTES - 1);
    for (int i = NOTES - 2; i >= 0; i--) begin
      if (below_mid[i]) begin
        degree = DEG_W'(i);
      end
    end
  end

  assign note_off = REL_W'(row[degree]) << FRAC_BITS;

  assign res = $signed({{2{pitch_i[PITCH_W-1]}}, pitch_i})
             - $signed(RES_W'(fold_i.rel))
             + $signed(RES_W'(note_off));

  always_comb begin
    if (res[RES_W-1:PITCH_W-1] == '0 || res[RES_W-1:PITCH_W-1] == '1) begin
      snapped_o = res[PITCH_W-1:0];
    end else if (res[RES_W-1]) begin
      snapped_o = {1'b1, {(PITCH_W-1){1'b0}}};
    end else begin
      snapped_o = {1'b0, {(PITCH_W-1){1'b1}}};
    end
  end

  assign degree_o = degree;

endmodule

`default_nettype wire

[hw/rtl/scale_pitch_quantizer_top.sv]
// Top level of the scale pitch quantizer: configuration registers, input
// register, result register. Depends on spq_pkg, spq_fold and spq_snap.
`default_nettype none

// How to use this block:
// An item is a signed pitch in semitones with FRAC_BITS fraction bits. It is
// taken on pitch_in_i at a rising edge where start_i is high and busy_o is
// low. busy_o stays low, so an item can be started in every cycle.
// Each item gives exactly one result: the pitch snapped to the nearest note
// of the configured scale, saturated to 16 bits, and the scale degree
// (7 means the root one octave up). The result sits on snapped_pitch_o and
// scale_degree_o for one cycle while done_o is high.
// An accepted item passes through the input register and then the result
// register, which drives done_o. Throughput is one item per cycle; the path
// between the input register and the result register is the octave fold,
// seven midpoint compares and one three-term add.
// The receiver cannot stall; results are not buffered, and the next result overwrites them.
// Configuration writes use cfg_valid_i/cfg_ready_o with cfg_index_i
// (0 root pitch, 1 scale mode) and cfg_data_i; cfg_ready_o is always high.
// Write configuration only when no item is in flight. Scale mode 3 acts as
// major. Reset clears the root to 0, the mode to major and drops any items
// in flight.

module scale_pitch_quantizer_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic [spq_pkg::PITCH_W-1:0]  pitch_in_i,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [0:0]                   cfg_index_i,
  input  wire logic [spq_pkg::CFG_W-1:0]    cfg_data_i,
  output logic                              done_o,
  output logic [spq_pkg::PITCH_W-1:0]       snapped_pitch_o,
  output logic [spq_pkg::DEG_W-1:0]         scale_degree_o
);
  import spq_pkg::*;

  logic                  accept;
  logic                  cfg_write;

  logic [ROOT_W-1:0]     root_q, root_d;
  logic [MODE_W-1:0]     mode_q, mode_d;

  logic                  in_vld_q;
  logic [PITCH_W-1:0]    pitch_q;

  fold_t                 fold;
  logic [PITCH_W-1:0]    snapped;
  logic [DEG_W-1:0]      degree;

  logic                  done_q;
  logic [PITCH_W-1:0]    snapped_q;
  logic [DEG_W-1:0]      degree_q;

  // Nothing ever holds the input side off.
  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  // Configuration register decode.
  always_comb begin
    root_d = root_q;
    mode_d = mode_q;
    if (cfg_write) begin
      case (cfg_index_i)
        CFG_ROOT_PITCH: root_d = cfg_data_i[ROOT_W-1:0];
        CFG_SCALE_MODE: mode_d = cfg_data_i[MODE_W-1:0];
        default: begin
          root_d = root_q;
          mode_d = mode_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
      mode_q <= MODE_MAJOR;
    end else begin
      root_q <= root_d;
      mode_q <= mode_d;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pitch_q <= pitch_in_i;
    end
  end

  spq_fold u_fold (
    .pitch_i (pitch_q),
    .root_i  (root_q),
    .fold_o  (fold)
  );

  spq_snap u_snap (
    .pitch_i   (pitch_q),
    .mode_i    (mode_q),
    .fold_i    (fold),
    .snapped_o (snapped),
    .degree_o  (degree)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      snapped_q <= snapped;
      degree_q  <= degree;
    end
  end

  assign done_o          = done_q;
  assign snapped_pitch_o = snapped_q;
  assign scale_degree_o  = degree_q;

  // Every accepted item yields a result strobe after the input and result registers.
  a_accept_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 done_o)
    else $error("accepted item did not produce a result");

  // No result strobe without an accepted item ahead of it in the input register.
  a_no_spurious_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> ##1 !done_o)
    else $error("result strobe without an accepted item");

  // The fold offset stays below one octave.
  a_rel_in_octave: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q |-> (fold.rel < REL_W'(12 << FRAC_BITS)))
    else $error("octave fold out of range");

  // Degree 7 is only chosen at or above the lowest top midpoint of any scale,
  // which is 11 semitones in natural minor.
  a_degree_top_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && degree == DEG_W'(NOTES - 1)) |->
      (fold.rel >= REL_W'(22 << (FRAC_BITS - 1))))
    else $error("top degree chosen below its midpoint");

endmodule

`default_nettype wire
